>>> src/mmalu_pkg.sv
// ----------------------------------------------------------------------------
// mmalu_pkg
// shared types and constants of the montgomery modular alu
// ----------------------------------------------------------------------------
package mmalu_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_BITS  = 3;
    localparam int RES_BITS = 31;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_MUL     = 3'd2,
        OP_CONV_IN = 3'd3,
        OP_CONV_OUT= 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CFG_MODULUS  = 2'd0,
        CFG_MOD_INV  = 2'd1,
        CFG_R_SQUARE = 2'd2
    } cfg_idx_t;

    // word carried from cell to cell
    typedef struct packed {
        logic                valid;
        logic [OP_BITS-1:0]  op;
        logic [63:0]         t;
        logic [31:0]         m;
        logic [31:0]         y;
    } stage_t;

endpackage

>>> src/mmalu_cell.sv
// ----------------------------------------------------------------------------
// mmalu_cell
// one pipeline cell: a registered step of the modular datapath, selected by
// the cell's position in the row
// ----------------------------------------------------------------------------
module mmalu_cell #(
    parameter int STEP      = 0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic [mmalu_pkg::WORD_W-2:0]   modulus,
    input  logic [mmalu_pkg::WORD_W-1:0]   modulus_inverse,
    input  logic [mmalu_pkg::WORD_W-2:0]   r_squared,
    input  mmalu_pkg::stage_t              d_in,
    input  logic [mmalu_pkg::WORD_W-1:0]   a_in,
    input  logic [mmalu_pkg::WORD_W-2:0]   b_in,
    output mmalu_pkg::stage_t              d_out
);

    mmalu_pkg::stage_t d_next;
    mmalu_pkg::stage_t d_reg;
    logic [31:0] n32;
    logic [31:0] sum;
    logic [63:0] mn;

    assign n32 = {1'b0, modulus};

    always_comb begin
        d_next = d_in;
        sum    = '0;
        mn     = '0;
        case (STEP)
            0: begin
                d_next.valid = d_in.valid;
                d_next.op    = d_in.op;
                d_next.m     = '0;
                d_next.y     = '0;
                case (d_in.op)
                    mmalu_pkg::OP_ADD: begin
                        sum = a_in + {1'b0, b_in};
                        d_next.y = (sum >= n32) ? sum - n32 : sum;
                        d_next.t = '0;
                    end
                    mmalu_pkg::OP_SUB: begin
                        sum = a_in - {1'b0, b_in};
                        d_next.y = sum[31] ? sum + n32 : sum;
                        d_next.t = '0;
                    end
                    mmalu_pkg::OP_MUL:      d_next.t = {32'd0, a_in} * {33'd0, b_in};
                    mmalu_pkg::OP_CONV_IN:  d_next.t = {32'd0, a_in} * {33'd0, r_squared};
                    mmalu_pkg::OP_CONV_OUT: d_next.t = {32'd0, a_in};
                    default:                d_next.t = '0;
                endcase
            end
            1: begin
                d_next.m = d_in.t[31:0] * modulus_inverse;
            end
            2: begin
                if (d_in.op == mmalu_pkg::OP_MUL || d_in.op == mmalu_pkg::OP_CONV_IN
                        || d_in.op == mmalu_pkg::OP_CONV_OUT) begin
                    mn = {32'd0, d_in.m} * {32'd0, n32};
                    sum = d_in.t[63:32] - mn[63:32];
                    d_next.y = sum[31] ? sum + n32 : sum;
                end
            end
            default: d_next = d_in;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.valid <= 1'b0;
        end else if (en) begin
            d_reg.valid <= d_next.valid;
        end
        if (en) begin
            d_reg.op <= d_next.op;
            d_reg.t  <= d_next.t;
            d_reg.m  <= d_next.m;
            d_reg.y  <= d_next.y;
        end
    end

    assign d_out = d_reg;

endmodule

>>> src/montgomery_modular_alu_core.sv
// ----------------------------------------------------------------------------
// montgomery_modular_alu_core
// a word moves from s_axis to its result on m_axis through a row of three cells
// throughput: one word per cycle while the row is not stalled
// (product or add/subtract, quotient multiply, reduction multiply and correction)
// the row stalls as a whole while a result waits with m_tready low
// synchronous active-low reset clears valid flags; registers reset to
// modulus 1, inverse 1, r squared 0
// ----------------------------------------------------------------------------
module montgomery_modular_alu_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] operand_a, [62:32] operand_b, [63] zero
    input  logic [63:0]                      s_tdata,
    // [2:0] op
    input  logic [mmalu_pkg::OP_BITS-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [30:0] result, [31] zero
    output logic [31:0]                      m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [mmalu_pkg::WORD_W-1:0]     cfg_data
);

    localparam int CELLS = 3;

    logic [mmalu_pkg::WORD_W-2:0] modulus_reg;
    logic [mmalu_pkg::WORD_W-1:0] modulus_inverse_reg;
    logic [mmalu_pkg::WORD_W-2:0] r_squared_reg;
    logic                         en;

    mmalu_pkg::stage_t chain [CELLS+1];
    logic [mmalu_pkg::WORD_W-1:0] a_in;
    logic [mmalu_pkg::WORD_W-2:0] b_in;

    assign en        = m_tready || !chain[CELLS].valid;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign a_in      = s_tdata[mmalu_pkg::WORD_W-1:0];
    assign b_in      = s_tdata[2*mmalu_pkg::WORD_W-2:mmalu_pkg::WORD_W];

    always_comb begin
        chain[0]       = '0;
        chain[0].valid = s_tvalid;
        chain[0].op    = s_tuser;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg         <= 31'd1;
            modulus_inverse_reg <= 32'd1;
            r_squared_reg       <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                mmalu_pkg::CFG_MODULUS:
                    modulus_reg <= cfg_data[mmalu_pkg::WORD_W-2:0];
                mmalu_pkg::CFG_MOD_INV:
                    modulus_inverse_reg <= cfg_data;
                mmalu_pkg::CFG_R_SQUARE:
                    r_squared_reg <= cfg_data[mmalu_pkg::WORD_W-2:0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        mmalu_cell #(.STEP(i)) u_cell (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .en              (en),
            .modulus         (modulus_reg),
            .modulus_inverse (modulus_inverse_reg),
            .r_squared       (r_squared_reg),
            .d_in            (chain[i]),
            .a_in            (a_in),
            .b_in            (b_in),
            .d_out           (chain[i+1])
        );
    end

    assign m_tvalid = chain[CELLS].valid;
    assign m_tdata  = {1'b0, chain[CELLS].y[mmalu_pkg::RES_BITS-1:0]};

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after three cycles");

endmodule
